// ----- sv/tpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tpt_pkg
// shared constants, types and tables of the tlb page table translator
// ----------------------------------------------------------------------------
`default_nettype none

package tpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;
  localparam int PAGE_BYTES  = 256;

  localparam int ADDR_W      = 16;
  localparam int OFFSET_W    = $clog2(PAGE_BYTES);
  localparam int PAGE_W      = ADDR_W - OFFSET_W;
  localparam int FRAME_W     = 8;
  localparam int CNT_W       = 16;
  localparam int FILL_W      = $clog2(TLB_ENTRIES + 1);
  localparam int PMAP_IDX_W  = $clog2(PAGE_COUNT);
  localparam int FREE_W      = FRAME_W + 1;
  localparam int FRAME_LIMIT = 1 << FRAME_W;
  localparam int PAGE_SPAN   = 1 << PAGE_W;

  typedef logic [PAGE_W-1:0]   page_t;
  typedef logic [FRAME_W-1:0]  frame_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [FILL_W-1:0]   fill_t;
  typedef logic [FREE_W-1:0]   free_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  localparam count_t CNT_MAX   = {CNT_W{1'b1}};
  localparam free_t  FREE_LIMIT = free_t'(FRAME_LIMIT);

  // what a tlb cell does at the clock edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    page_t  page;
    frame_t frame;
  } tlb_entry_t;

  // ripple from older to younger cell: first match and its frame
  typedef struct packed {
    logic   found;
    frame_t frame;
  } cell_link_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } tpt_state_t;

  // page number folded into the page map range
  typedef page_t page_wrap_t [PAGE_SPAN];

  function automatic page_wrap_t build_page_wrap();
    page_wrap_t t;
    for (int i = 0; i < PAGE_SPAN; i++) begin
      t[i] = page_t'(i % PAGE_COUNT);
    end
    return t;
  endfunction

  localparam page_wrap_t PAGE_WRAP = build_page_wrap();

endpackage

`default_nettype wire

// ----- sv/tpt_in_if.sv -----
// ----------------------------------------------------------------------------
// tpt_in_if
// address channel: one logical address per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface tpt_in_if import tpt_pkg::*; ();
  logic  valid;
  logic  ready;
  addr_t virt_addr;

  modport source (output valid, output virt_addr, input ready);
  modport sink   (input valid, input virt_addr, output ready);
endinterface

`default_nettype wire

// ----- sv/tpt_out_if.sv -----
// ----------------------------------------------------------------------------
// tpt_out_if
// translation result channel: one result per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface tpt_out_if import tpt_pkg::*; ();
  logic   valid;
  logic   ready;
  frame_t frame_number;
  addr_t  physical_address;
  logic   tlb_hit;
  logic   page_fault;
  count_t total_faults;
  count_t total_hits;

  modport source (
    output valid, output frame_number, output physical_address,
    output tlb_hit, output page_fault, output total_faults, output total_hits,
    input  ready
  );
  modport sink (
    input  valid, input frame_number, input physical_address,
    input  tlb_hit, input page_fault, input total_faults, input total_hits,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/tlb_page_table_translator.sv -----
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// logical to physical address translation through an lru tlb and a page
// map with demand allocation of frames
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------
//  in_ch   | in  | virt_addr (page in upper byte, offset in lower)
//  out_ch  | out | frame_number, physical_address, tlb_hit, page_fault,
//          |     | total_faults, total_hits
//
//  each address goes through an accept cycle and a lookup cycle: the accept cycle folds the page and reads the
//  page map frame memory, the next cycle compares across the tlb cells and
//  commits tlb, page map and counters into the result register
//  a full result register holds the lookup cycle until out_ch takes its beat
//  reset clears the tlb fill count, the present bits, the free frame pointer
//  and both counters directly, no clearing pass
//
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_page_table_translator import tpt_pkg::*; (
  input wire                clk,
  input wire                rst_n,
  tpt_in_if.sink            in_ch,
  tpt_out_if.source         out_ch
);

  tpt_state_t state_r;
  tpt_state_t state_nxt;

  // request held across the lookup cycle
  page_t   page_r;
  offset_t offset_r;
  page_t   in_page;

  logic    accept;
  logic    commit;

  // lookup results
  logic    hit;
  frame_t  hit_frame;
  logic    present;
  frame_t  map_frame;
  frame_t  frame;
  logic    alloc;

  // result register and counters
  logic    out_valid_r;
  logic    out_valid_nxt;
  frame_t  out_frame_r;
  offset_t out_offset_r;
  logic    out_hit_r;
  logic    out_fault_r;
  count_t  fault_cnt_r;
  count_t  fault_cnt_nxt;
  count_t  hit_cnt_r;
  count_t  hit_cnt_nxt;

  // page numbers beyond the map wrap around
  assign in_page = PAGE_WRAP[in_ch.virt_addr[ADDR_W-1:OFFSET_W]];

  // ---------------- control
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_LOOK;
      ST_LOOK: if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    commit      = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      // commit only when the result register is free or drains this cycle
      ST_LOOK: commit = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page_r   <= in_page;
      offset_r <= in_ch.virt_addr[OFFSET_W-1:0];
    end
  end

  // ---------------- lookup
  tpt_tlb u_tlb (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_page (page_r),
    .commit      (commit),
    .new_frame   (frame),
    .hit         (hit),
    .hit_frame   (hit_frame)
  );

  // page map read is issued with the accept so data is ready for the lookup
  tpt_page_map u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_page  (in_page),
    .cur_page (page_r),
    .alloc    (alloc),
    .present  (present),
    .frame    (map_frame)
  );

  assign frame = hit ? hit_frame : map_frame;
  assign alloc = commit && !hit && !present;

  // ---------------- counters, saturating
  always_comb begin
    fault_cnt_nxt = fault_cnt_r;
    hit_cnt_nxt   = hit_cnt_r;
    if (commit && hit && (hit_cnt_r != CNT_MAX)) begin
      hit_cnt_nxt = hit_cnt_r + count_t'(1);
    end
    if (alloc && (fault_cnt_r != CNT_MAX)) begin
      fault_cnt_nxt = fault_cnt_r + count_t'(1);
    end
  end

  // ---------------- result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fault_cnt_r <= '0;
      hit_cnt_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_frame_r  <= frame;
      out_offset_r <= offset_r;
      out_hit_r    <= hit;
      out_fault_r  <= alloc;
    end
  end

  // counters only move on a commit, which also reloads the result register
  assign out_ch.valid            = out_valid_r;
  assign out_ch.frame_number     = out_frame_r;
  assign out_ch.physical_address = {out_frame_r, out_offset_r};
  assign out_ch.tlb_hit          = out_hit_r;
  assign out_ch.page_fault       = out_fault_r;
  assign out_ch.total_faults     = fault_cnt_r;
  assign out_ch.total_hits       = hit_cnt_r;

endmodule

`default_nettype wire

// ----- sv/tpt_tlb_cell.sv -----
// ----------------------------------------------------------------------------
// tpt_tlb_cell
// one tlb slot: compares its page, ripples the first match, shifts or loads
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_tlb_cell import tpt_pkg::*; (
  input  wire         clk,
  input  cell_op_t    op,
  input  page_t       lookup_page,
  input  logic        filled,
  input  tlb_entry_t  new_entry,
  input  tlb_entry_t  nb_entry,
  input  cell_link_t  link_in,
  output cell_link_t  link_out,
  output tlb_entry_t  entry
);

  tlb_entry_t entry_r;
  logic       match;

  assign match = filled && (entry_r.page == lookup_page);

  // only the oldest matching slot contributes its frame
  assign link_out.found = link_in.found | match;
  assign link_out.frame = link_in.frame |
                          ((match && !link_in.found) ? entry_r.frame : '0);
  assign entry = entry_r;

  always_ff @(posedge clk) begin
    case (op)
      CELL_SHIFT: entry_r <= nb_entry;
      CELL_LOAD:  entry_r <= new_entry;
      default:    entry_r <= entry_r;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/tpt_tlb.sv -----
// ----------------------------------------------------------------------------
// tpt_tlb
// lru-ordered tlb as a row of cells, slot 0 oldest
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_tlb import tpt_pkg::*; (
  input  wire     clk,
  input  wire     rst_n,
  input  page_t   lookup_page,
  input  logic    commit,
  input  frame_t  new_frame,
  output logic    hit,
  output frame_t  hit_frame
);

  fill_t       fill_r;
  fill_t       fill_nxt;
  cell_link_t  link [TLB_ENTRIES+1];
  tlb_entry_t  entry [TLB_ENTRIES];
  cell_op_t    ops [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] found;
  logic [TLB_ENTRIES-1:0] filled;
  tlb_entry_t  new_entry;
  logic        full;

  assign link[0]   = '0;
  assign hit       = link[TLB_ENTRIES].found;
  assign hit_frame = link[TLB_ENTRIES].frame;
  assign new_entry = '{page: lookup_page, frame: new_frame};
  assign full      = (fill_r == fill_t'(TLB_ENTRIES));

  for (genvar k = 0; k < TLB_ENTRIES; k++) begin : g_cell
    tlb_entry_t nb;

    assign found[k]  = link[k+1].found;
    assign filled[k] = (fill_t'(k) < fill_r);

    if (k == TLB_ENTRIES - 1) begin : g_last
      assign nb = new_entry;
    end else begin : g_mid
      assign nb = entry[k+1];
    end

    tpt_tlb_cell u_cell (
      .clk         (clk),
      .op          (ops[k]),
      .lookup_page (lookup_page),
      .filled      (filled[k]),
      .new_entry   (new_entry),
      .nb_entry    (nb),
      .link_in     (link[k]),
      .link_out    (link[k+1]),
      .entry       (entry[k])
    );
  end

  // hit: slots from the match up close the gap, the entry goes to the youngest
  // miss: append, or shift everything down when full
  always_comb begin
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      ops[k] = CELL_HOLD;
      if (commit) begin
        if (hit) begin
          if (fill_t'(k + 1) == fill_r) begin
            ops[k] = CELL_LOAD;
          end else if ((fill_t'(k + 1) < fill_r) && found[k]) begin
            ops[k] = CELL_SHIFT;
          end
        end else if (!full) begin
          if (fill_t'(k) == fill_r) begin
            ops[k] = CELL_LOAD;
          end
        end else if (k == TLB_ENTRIES - 1) begin
          ops[k] = CELL_LOAD;
        end else begin
          ops[k] = CELL_SHIFT;
        end
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (commit && !hit && !full) begin
      fill_nxt = fill_r + fill_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tpt_page_map.sv -----
// ----------------------------------------------------------------------------
// tpt_page_map
// page map: present bits, frame memory and the free frame pointer
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_page_map import tpt_pkg::*; (
  input  wire     clk,
  input  wire     rst_n,
  input  logic    rd_en,
  input  page_t   rd_page,
  input  page_t   cur_page,
  input  logic    alloc,
  output logic    present,
  output frame_t  frame
);

  logic [PAGE_COUNT-1:0] present_r;
  logic [PAGE_COUNT-1:0] present_nxt;
  frame_t                frame_mem [PAGE_COUNT];
  frame_t                rdata_r;
  free_t                 free_r;
  free_t                 free_nxt;
  logic [PMAP_IDX_W-1:0] cur_idx;
  logic [PMAP_IDX_W-1:0] rd_idx;
  frame_t                free_frame;

  assign cur_idx    = cur_page[PMAP_IDX_W-1:0];
  assign rd_idx     = rd_page[PMAP_IDX_W-1:0];
  assign free_frame = free_r[FRAME_W-1:0];
  assign present    = present_r[cur_idx];
  // an absent page takes the next free frame
  assign frame      = present ? rdata_r : free_frame;

  always_comb begin
    present_nxt = present_r;
    free_nxt    = free_r;
    if (alloc) begin
      present_nxt[cur_idx] = 1'b1;
      if (free_r < FREE_LIMIT) begin
        free_nxt = free_r + free_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      free_r    <= '0;
    end else begin
      present_r <= present_nxt;
      free_r    <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc) begin
      frame_mem[cur_idx] <= free_frame;
    end
    if (rd_en) begin
      rdata_r <= frame_mem[rd_idx];
    end
  end

endmodule

`default_nettype wire

// ----- sv/tpt_chk.sv -----
// ----------------------------------------------------------------------------
// tpt_chk
// port-level checks of the translator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_chk import tpt_pkg::*; (
  input wire    clk,
  input wire    rst_n,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input frame_t frame_number,
  input addr_t  physical_address,
  input logic   tlb_hit,
  input logic   page_fault,
  input count_t total_faults,
  input count_t total_hits
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(physical_address) &&
                                $stable(tlb_hit) && $stable(page_fault))
    else $error("result beat changed while stalled");

  // an address is looked up before the next one is taken, so no accept right after an accept
  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("address accepted during lookup");

  a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(tlb_hit && page_fault))
    else $error("hit and fault in one beat");

  // frames are handed out in order, so a fault gets fault count minus one
  a_fault_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && page_fault |-> total_faults == (count_t'(frame_number) + count_t'(1)))
    else $error("faulting page got an unexpected frame");

  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && tlb_hit |-> total_hits != '0)
    else $error("hit beat with zero hit count");

endmodule

bind tlb_page_table_translator tpt_chk u_tpt_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .frame_number     (out_ch.frame_number),
  .physical_address (out_ch.physical_address),
  .tlb_hit          (out_ch.tlb_hit),
  .page_fault       (out_ch.page_fault),
  .total_faults     (out_ch.total_faults),
  .total_hits       (out_ch.total_hits)
);

`default_nettype wire
